// ===== sv/tpct_pkg.sv =====
// ----------------------------------------------------------------------------
// tpct_pkg
// Shared constants, codes and types of the TCP probe connection tracker.
// ----------------------------------------------------------------------------
package tpct_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;

    localparam int IN_W  = 240;   // packed input word, byte aligned
    localparam int OUT_W = 104;   // packed result word, byte aligned
    localparam int CFG_W = 16;

    localparam logic [5:0]  FLAG_MASK     = 6'h3F;
    localparam logic [31:0] ACK_WINDOW    = 32'd2;
    localparam logic [16:0] MIN_HDR_BYTES = 17'd40;

    localparam logic [5:0] FL_SYN_ACK = 6'h12;
    localparam logic [5:0] FL_FIN_ACK = 6'h11;
    localparam logic [5:0] FL_RST     = 6'h04;
    localparam logic [5:0] FL_RST_ACK = 6'h14;

    typedef enum logic [2:0] {
        ACT_IGNORED   = 3'd0,
        ACT_INSERTED  = 3'd1,
        ACT_DUPLICATE = 3'd2,
        ACT_FULL      = 3'd3,
        ACT_MATCHED   = 3'd4,
        ACT_FWD_DEL   = 3'd5,
        ACT_NONE      = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        REG_LINK_OFFSET = 2'd0,
        REG_CLEANUP     = 2'd1,
        REG_EXPIRE      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] stamp_sec;
        logic [19:0] stamp_usec;
        logic [31:0] ack;
        logic [31:0] ports;
        logic [63:0] addrs;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_run;
        logic sweep_mode;
        logic commit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sweep_due;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/tpct_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpct_ctrl
// Sequencer: accept word, optional expiry sweep, lookup scan, commit.
// ----------------------------------------------------------------------------
module tpct_ctrl
    import tpct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_tvalid,
    output logic in_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHOOSE,
        S_SWEEP,
        S_RECLR,
        S_LOOK,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_tready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHOOSE;
                end
            end
            S_CHOOSE:
            begin
                cmd.scan_clr = 1'b1;
                state_next   = sts.sweep_due ? S_SWEEP : S_LOOK;
            end
            S_SWEEP:
            begin
                cmd.scan_run   = 1'b1;
                cmd.sweep_mode = 1'b1;
                if (sts.scan_done)
                    state_next = S_RECLR;
            end
            S_RECLR:
            begin
                cmd.scan_clr = 1'b1;
                state_next   = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/tpct_datapath.sv =====
// ----------------------------------------------------------------------------
// tpct_datapath
// Connection table memory, scan pipeline, expiry test and result register.
// ----------------------------------------------------------------------------
module tpct_datapath
    import tpct_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [IN_W-1:0]    in_tdata,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               out_tvalid,
    input  logic               out_tready,
    output logic [OUT_W-1:0]   out_tdata
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

    // configuration
    logic [7:0]  link_off_reg;
    logic [15:0] cleanup_reg;
    logic [15:0] expire_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_off_reg <= 8'd14;
            cleanup_reg  <= 16'd1000;
            expire_reg   <= 16'd60;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINK_OFFSET: link_off_reg <= cfg_data[7:0];
                REG_CLEANUP:     cleanup_reg  <= cfg_data;
                REG_EXPIRE:      expire_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // held packet fields
    logic [15:0] frame_len_reg;
    logic [7:0]  flags_reg;
    logic [31:0] src_ip_reg, dst_ip_reg, seq_reg, ack_reg, tsec_reg;
    logic [15:0] sport_reg, dport_reg;
    logic [19:0] tusec_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_len_reg <= in_tdata[15:0];
            flags_reg     <= in_tdata[23:16];
            src_ip_reg    <= in_tdata[55:24];
            dst_ip_reg    <= in_tdata[87:56];
            sport_reg     <= in_tdata[103:88];
            dport_reg     <= in_tdata[119:104];
            seq_reg       <= in_tdata[151:120];
            ack_reg       <= in_tdata[183:152];
            tsec_reg      <= in_tdata[215:184];
            tusec_reg     <= in_tdata[235:216];
        end
    end

    // packet counter for sweep timing
    logic [15:0] pkt_cnt_reg;
    logic        sweep_due_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_cnt_reg   <= '0;
            sweep_due_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (pkt_cnt_reg > cleanup_reg)
            begin
                pkt_cnt_reg   <= '0;
                sweep_due_reg <= 1'b1;
            end
            else
            begin
                sweep_due_reg <= 1'b0;
                if (pkt_cnt_reg != 16'hFFFF)
                    pkt_cnt_reg <= pkt_cnt_reg + 16'd1;
            end
        end
    end

    // table
    entry_t                   mem [TABLE_ENTRIES];
    entry_t                   rd_data_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [CW-1:0] cnt_reg;
    logic          p_vld_reg;
    logic [IW-1:0] p_idx_reg;
    logic          issue;

    logic          fwd_hit_reg, rev_hit_reg, free_hit_reg;
    logic [IW-1:0] fwd_idx_reg, rev_idx_reg, free_idx_reg;
    logic [31:0]   rev_ack_reg;

    logic [63:0] fwd_addrs, rev_addrs;
    logic [31:0] fwd_ports, rev_ports;
    logic        cur_v, borrow, expired, fwd_m, rev_m;
    logic signed [33:0] age;

    assign issue     = cmd.scan_run && (cnt_reg < LAST_CNT);
    assign fwd_addrs = {src_ip_reg, dst_ip_reg};
    assign rev_addrs = {dst_ip_reg, src_ip_reg};
    assign fwd_ports = {sport_reg, dport_reg};
    assign rev_ports = {dport_reg, sport_reg};
    assign cur_v     = valid_reg[p_idx_reg];
    assign borrow    = tusec_reg < rd_data_reg.stamp_usec;
    assign age       = $signed({2'b00, tsec_reg}) - $signed({2'b00, rd_data_reg.stamp_sec})
                     - $signed({33'd0, borrow});
    assign expired   = age > $signed({18'd0, expire_reg});
    assign fwd_m     = (rd_data_reg.addrs == fwd_addrs) && (rd_data_reg.ports == fwd_ports);
    assign rev_m     = (rd_data_reg.addrs == rev_addrs) && (rd_data_reg.ports == rev_ports);

    // decision
    logic [5:0]  flags6;
    logic        len_ok, is_syn, is_close, alarm;
    logic [31:0] hi;
    action_t     act;
    logic        do_ins, do_clr;
    logic [IW-1:0] clr_idx;

    always_comb
    begin
        flags6   = flags_reg[5:0] & FLAG_MASK;
        len_ok   = {1'b0, frame_len_reg} >= ({9'd0, link_off_reg} + MIN_HDR_BYTES);
        is_syn   = flags6 == FL_SYN_ACK;
        is_close = (flags6 == FL_FIN_ACK) || (flags6 == FL_RST) || (flags6 == FL_RST_ACK);
        hi       = rev_ack_reg + ACK_WINDOW;
        alarm    = 1'b0;
        act      = ACT_IGNORED;
        do_ins   = 1'b0;
        do_clr   = 1'b0;
        clr_idx  = rev_idx_reg;
        if (len_ok && is_syn)
        begin
            if (fwd_hit_reg)
                act = ACT_DUPLICATE;
            else if (free_hit_reg)
            begin
                act    = ACT_INSERTED;
                do_ins = 1'b1;
            end
            else
                act = ACT_FULL;
        end
        else if (len_ok && is_close)
        begin
            if (rev_hit_reg)
            begin
                act    = ACT_MATCHED;
                do_clr = 1'b1;
                alarm  = (seq_reg >= rev_ack_reg) && (seq_reg <= hi);
            end
            else if (fwd_hit_reg)
            begin
                act     = ACT_FWD_DEL;
                do_clr  = 1'b1;
                clr_idx = fwd_idx_reg;
            end
            else
                act = ACT_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_ins)
            mem[free_idx_reg] <= '{stamp_sec: tsec_reg, stamp_usec: tusec_reg,
                                   ack: ack_reg, ports: fwd_ports, addrs: fwd_addrs};
        if (issue)
            rd_data_reg <= mem[cnt_reg[IW-1:0]];
        if (issue)
            p_idx_reg <= cnt_reg[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            cnt_reg      <= '0;
            p_vld_reg    <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            rev_hit_reg  <= 1'b0;
            free_hit_reg <= 1'b0;
            fwd_idx_reg  <= '0;
            rev_idx_reg  <= '0;
            free_idx_reg <= '0;
            rev_ack_reg  <= '0;
        end
        else if (cmd.scan_clr)
        begin
            cnt_reg      <= '0;
            p_vld_reg    <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            rev_hit_reg  <= 1'b0;
            free_hit_reg <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            p_vld_reg <= issue;
            if (issue)
                cnt_reg <= cnt_reg + CW'(1);
            if (p_vld_reg)
            begin
                if (cmd.sweep_mode)
                begin
                    if (cur_v && expired)
                        valid_reg[p_idx_reg] <= 1'b0;
                end
                else if (cur_v)
                begin
                    if (fwd_m && !fwd_hit_reg)
                    begin
                        fwd_hit_reg <= 1'b1;
                        fwd_idx_reg <= p_idx_reg;
                    end
                    if (rev_m && !rev_hit_reg)
                    begin
                        rev_hit_reg <= 1'b1;
                        rev_idx_reg <= p_idx_reg;
                        rev_ack_reg <= rd_data_reg.ack;
                    end
                end
                else if (!free_hit_reg)
                begin
                    free_hit_reg <= 1'b1;
                    free_idx_reg <= p_idx_reg;
                end
            end
        end
        else if (cmd.commit)
        begin
            if (do_ins)
                valid_reg[free_idx_reg] <= 1'b1;
            if (do_clr)
                valid_reg[clr_idx] <= 1'b0;
        end
    end

    // result register
    logic              out_vld_reg;
    logic [OUT_W-1:0]  out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.commit)
            out_vld_reg <= 1'b1;
        else if (out_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_data_reg <= {4'd0,
                             alarm ? sport_reg  : 16'd0,
                             alarm ? src_ip_reg : 32'd0,
                             alarm ? dport_reg  : 16'd0,
                             alarm ? dst_ip_reg : 32'd0,
                             alarm, act};
    end

    assign out_tvalid    = out_vld_reg;
    assign out_tdata     = out_data_reg;
    assign sts.sweep_due = sweep_due_reg;
    assign sts.scan_done = (cnt_reg == LAST_CNT) && !p_vld_reg;
    assign sts.out_free  = !out_vld_reg || out_tready;

endmodule

// ===== sv/tcp_probe_connection_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tcp_probe_connection_tracker_core
// Tracks SYN+ACK handshakes and flags closes whose seq lies within ACK_WINDOW of the stored ack.
// ----------------------------------------------------------------------------
//  channel  | dir | width | contents
//  s_axis   | in  | 240   | one parsed packet header word
//  m_axis   | out | 104   | one result word per packet
//  cfg      | in  | 16    | register writes, index 0..2
//
//  The lookup walks the table memory one entry per cycle through its single
//  read port. A due sweep first walks the table over that same port.
//  Reset clears the valid bits, packet counter and config to defaults.
//  A stalled result waits in the output register; the next packet is already
//  accepted and scanned meanwhile, committing once the register frees.
// ----------------------------------------------------------------------------
module tcp_probe_connection_tracker_core
    import tpct_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // frame_len, tcp_flag_bits, src_ip, dst_ip, src_tcp_port, dst_tcp_port,
    // seq_num, ack_num, time_sec, time_usec, zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // action, probe_alarm, alarm_dst_ip, alarm_dst_port, alarm_src_ip,
    // alarm_src_port, zero pad
    output logic [OUT_W-1:0]  m_axis_tdata
);

    cmd_t cmd;
    sts_t sts;

    tpct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tpct_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_tdata   (s_axis_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata)
    );

    // one packet in flight
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second packet accepted while busy");

    // alarm only on a matched close
    a_alarm_action: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:0] == ACT_MATCHED))
        else $error("alarm without matched close");

    // no alarm, no reported tuple
    a_alarm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[3]) |-> (m_axis_tdata[99:4] == '0))
        else $error("alarm fields set without alarm");

endmodule
